// ===== hw/rtl/udec_pkg.sv =====
// ----------------------------------------------------------------------------
// udec_pkg
// Shared types, codes and helpers for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
package udec_pkg;

  // Default depth of the internal queues
  localparam int unsigned UDEC_FIFO_DEPTH = 2;

  // Largest Unicode scalar value and the surrogate range
  localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;

  // Lowest and highest legal lead bytes
  localparam logic [7:0] LEAD_MIN = 8'hC2;
  localparam logic [7:0] LEAD_MAX = 8'hF4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_DONE    = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  // Byte classes worked out by the front end
  typedef enum logic [1:0] {
    KIND_ASCII = 2'd0,
    KIND_LEAD  = 2'd1,
    KIND_CONT  = 2'd2,
    KIND_BAD   = 2'd3
  } kind_e;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_buffer;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    status_e     status;
    logic [20:0] code_point;
  } out_item_t;

  // Classified byte passed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  cnt;    // continuation bytes due after a lead
    logic [20:0] value;  // ASCII value, lead bits in place, or 6 payload bits
  } mid_item_t;

  // True for a legal scalar value (no surrogates, nothing above 10FFFF)
  function automatic logic scalar_ok(input logic [20:0] v);
    logic ok;
    ok = (v <= MAX_SCALAR) && !((v >= SURR_LO) && (v <= SURR_HI));
    return ok;
  endfunction

endpackage

// ===== hw/rtl/udec_fifo.sv =====
// ----------------------------------------------------------------------------
// udec_fifo
// Small register-based queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module udec_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2   // 2 .. 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/udec_front.sv =====
// ----------------------------------------------------------------------------
// udec_front
// Classifies each incoming byte independently of the decoder state.
// ----------------------------------------------------------------------------
module udec_front (
  input  udec_pkg::in_item_t  item_i,
  output udec_pkg::mid_item_t mid_o
);
  import udec_pkg::*;

  logic [7:0] b;

  // No-buffer flag forces a zero byte
  assign b = item_i.no_buffer ? 8'h00 : item_i.data_byte;

  always_comb begin
    mid_o.kind  = KIND_BAD;
    mid_o.cnt   = 2'd0;
    mid_o.value = '0;
    if (!b[7]) begin
      mid_o.kind  = KIND_ASCII;
      mid_o.value = {13'b0, b};
    end else if (b[7:6] == 2'b10) begin
      // continuation: keep the six payload bits
      mid_o.kind  = KIND_CONT;
      mid_o.value = {15'b0, b[5:0]};
    end else if (b inside {[LEAD_MIN:LEAD_MAX]}) begin
      mid_o.kind = KIND_LEAD;
      if (b < 8'hE0) begin
        mid_o.cnt   = 2'd1;
        mid_o.value = {10'b0, b[4:0], 6'b0};
      end else if (b < 8'hF0) begin
        mid_o.cnt   = 2'd2;
        mid_o.value = {5'b0, b[3:0], 12'b0};
      end else begin
        mid_o.cnt   = 2'd3;
        mid_o.value = {b[2:0], 18'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/udec_back.sv =====
// ----------------------------------------------------------------------------
// udec_back
// Holds the sequence state and turns each classified byte into a result.
// ----------------------------------------------------------------------------
module udec_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  udec_pkg::mid_item_t mid_i,
  input  logic                ready_i,
  output logic                fire_o,
  output udec_pkg::out_item_t res_o
);
  import udec_pkg::*;

  logic [20:0] partial_q, partial_d;
  logic [1:0]  rem_q, rem_d;
  logic [5:0]  c;
  logic [20:0] shifted;
  logic [20:0] v;
  logic        overlong;

  assign fire_o = valid_i && ready_i;
  assign c      = mid_i.value[5:0];

  // Continuation payload placed by the number of bytes still due
  always_comb begin
    case (rem_q)
      2'd1:    shifted = {15'b0, c};
      2'd2:    shifted = {9'b0, c, 6'b0};
      2'd3:    shifted = {3'b0, c, 12'b0};
      default: shifted = '0;
    endcase
  end

  assign v = partial_q | shifted;

  // Overlong forms: too small a first continuation after an empty lead
  assign overlong = (partial_q == '0) &&
                    ((rem_q == 2'd1) ||
                     ((rem_q == 2'd2) && (c < 6'h20)) ||
                     ((rem_q == 2'd3) && (c < 6'h10)));

  // Result and next state; an error leaves the state alone
  always_comb begin
    partial_d      = partial_q;
    rem_d          = rem_q;
    res_o.status   = ST_ERROR;
    res_o.code_point = '0;
    case (mid_i.kind)
      KIND_ASCII: begin
        if (rem_q == 2'd0) begin
          res_o.status     = ST_DONE;
          res_o.code_point = mid_i.value;
        end
      end
      KIND_LEAD: begin
        if (rem_q == 2'd0) begin
          res_o.status = ST_PENDING;
          partial_d    = mid_i.value;
          rem_d        = mid_i.cnt;
        end
      end
      KIND_CONT: begin
        if ((rem_q != 2'd0) && !overlong && scalar_ok(v)) begin
          rem_d = rem_q - 2'd1;
          if (rem_q == 2'd1) begin
            res_o.status     = ST_DONE;
            res_o.code_point = v;
            partial_d        = '0;
          end else begin
            res_o.status = ST_PENDING;
            partial_d    = v;
          end
        end
      end
      default: begin
        res_o.status = ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      rem_q     <= '0;
    end else if (fire_o) begin
      partial_q <= partial_d;
      rem_q     <= rem_d;
    end
  end

endmodule

// ===== hw/rtl/utf8_byte_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_decoder_unit
// UTF-8 decoder with validation, one byte in and one result out per step.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while full is low and returns one result per
// byte: pending, a finished code point, or an illegal-sequence error (state
// kept on error). Sustained rate is one byte per clock while neither queue
// stalls, set by the state update in the back end; an accepted byte is
// registered in the classify queue, and its result in the result queue,
// before the result can be popped. A classify queue and a result queue of
// FifoDepth entries each let the input and output sides stall independently.
module utf8_byte_decoder_unit #(
  parameter int unsigned FifoDepth = udec_pkg::UDEC_FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  udec_pkg::in_item_t  item_i,
  output logic                full,
  input  logic                pop,
  output udec_pkg::out_item_t result_o,
  output logic                empty
);
  import udec_pkg::*;

  mid_item_t mid_wr, mid_rd;
  out_item_t res;
  logic      mid_empty, res_full, back_fire;

  // Front end: byte classification
  udec_front u_front (
    .item_i (item_i),
    .mid_o  (mid_wr)
  );

  // Queue between front and back
  udec_fifo #(
    .Width ($bits(mid_item_t)),
    .Depth (FifoDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (mid_wr),
    .full_o  (full),
    .pop_i   (back_fire),
    .rdata_o (mid_rd),
    .empty_o (mid_empty)
  );

  // Back end: sequence state and result
  udec_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!mid_empty),
    .mid_i   (mid_rd),
    .ready_i (!res_full),
    .fire_o  (back_fire),
    .res_o   (res)
  );

  // Result queue
  udec_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (FifoDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_fire),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

  // Back end never consumes while the result queue is full
  a_no_fire_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_full |-> !back_fire) else $error("back end fired into a full result queue");

  // An accepted byte is waiting for the back end in the next cycle
  a_push_reaches_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !mid_empty) else $error("accepted byte lost before back end");

  // A finished code point is always a legal scalar value
  a_done_is_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_fire && (res.status == ST_DONE)) |-> scalar_ok(res.code_point))
    else $error("completed code point is not a scalar value");

  // Pending and error results carry a zero code point
  a_not_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_fire && (res.status != ST_DONE)) |-> (res.code_point == '0))
    else $error("non-final result carries a code point");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the UTF-8 byte decoder unit.
// ----------------------------------------------------------------------------
// Bytes go in through the push/full side and results come back through the
// pop/empty side. A decoder model inside the bench tracks the partial code
// point and the continuation count, and queues one expected result for
// every byte transaction. Each popped result is checked field by field
// against the oldest entry. A short directed part covers the byte extremes
// and each rejection rule. Random streams of well-formed sequences, mixed
// with noise, truncation, overlong forms, surrogates and out-of-range values,
// then run under four pacing phases on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import udec_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTED = 50;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      pop = 1'b0;
  out_item_t result;
  logic      empty;

  // Decoder state mirrored by the bench
  logic [20:0] partial_cp = '0;
  logic [2:0]  conts_due = '0;

  out_item_t   pending_results[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned points_done = 0;
  int unsigned bytes_rejected = 0;
  int unsigned mismatch_count = 0;

  utf8_byte_decoder_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item),
    .full     (full),
    .pop      (pop),
    .result_o (result),
    .empty    (empty)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle count and run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver pacing
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  // Print one mismatch line (capped) and count it
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
  endtask

  function automatic logic is_scalar(input logic [20:0] v);
    return (v < 21'h110000) && !((v >= 21'h00D800) && (v <= 21'h00DFFF));
  endfunction

  // Decode one byte against the mirrored state; state is kept on error
  function automatic out_item_t decode_byte(input in_item_t it);
    logic [7:0]  b;
    logic [20:0] v;
    logic [20:0] c;
    logic [2:0]  n;
    out_item_t   r;
    b = it.no_buffer ? 8'h00 : it.data_byte;
    r.status = ST_ERROR;
    r.code_point = '0;
    if (b[7] == 1'b0) begin
      // ASCII: only legal between sequences
      if (conts_due == 3'd0) begin
        r.status = ST_DONE;
        r.code_point = {13'd0, b};
      end
    end else if (b[7:6] == 2'b11) begin
      // lead byte
      if (conts_due == 3'd0 && b >= LEAD_MIN && b < 8'hF8) begin
        n = (b < 8'hE0) ? 3'd1 : (b < 8'hF0) ? 3'd2 : 3'd3;
        v = {13'd0, b & (8'hFF >> (n + 3'd2))} << (6 * n);
        if (is_scalar(v)) begin
          partial_cp = v;
          conts_due = n;
          r.status = ST_PENDING;
        end
      end
    end else begin
      // continuation byte
      c = {15'd0, b[5:0]};
      if (conts_due != 3'd0 && conts_due <= 3'd3 &&
          !(partial_cp == 21'd0 && c < (21'h80 >> conts_due))) begin
        n = conts_due - 3'd1;
        v = partial_cp | (c << (6 * n));
        if (is_scalar(v)) begin
          conts_due = n;
          if (n != 3'd0) begin
            partial_cp = v;
            r.status = ST_PENDING;
          end else begin
            partial_cp = '0;
            r.status = ST_DONE;
            r.code_point = v;
          end
        end
      end
    end
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (result.status == ST_DONE) points_done++;
      if (result.status == ST_ERROR) bytes_rejected++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d code point %h",
                                  result.status, result.code_point));
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d", results_seen,
                                    result.status, want.status));
        if (result.code_point !== want.code_point)
          report_mismatch($sformatf("result %0d code point %h, want %h", results_seen,
                                    result.code_point, want.code_point));
      end
    end
  end

  // Send one byte transaction, with sender gaps as set by idle_pct
  task automatic send_byte(input logic [7:0] b, input logic nb);
    in_item_t it;
    it.data_byte = b;
    it.no_buffer = nb;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_results.push_back(decode_byte(it));
    bytes_sent++;
  endtask

  // Encode cp as a len-byte sequence and send the first keep bytes
  task automatic send_encoded(input logic [20:0] cp, input int unsigned len,
                              input int unsigned keep);
    logic [7:0] b;
    for (int unsigned k = 0; k < keep; k++) begin
      if (k == 0) begin
        case (len)
          1:       b = {1'b0, cp[6:0]};
          2:       b = {3'b110, cp[10:6]};
          3:       b = {4'b1110, cp[15:12]};
          default: b = {5'b11110, cp[20:18]};
        endcase
      end else begin
        b = {2'b10, 6'(cp >> (6 * (len - 1 - k)))};
      end
      send_byte(b, 1'b0);
    end
  endtask

  // Legal scalar of a random length, sometimes at the edge of its range
  task automatic send_random_scalar();
    int unsigned len;
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    int unsigned pick;
    len = $urandom_range(4, 1);
    case (len)
      1:       begin lo = 21'h0;     hi = 21'h7F;     end
      2:       begin lo = 21'h80;    hi = 21'h7FF;    end
      3:       begin lo = 21'h800;   hi = 21'hFFFF;   end
      default: begin lo = 21'h10000; hi = 21'h10FFFF; end
    endcase
    pick = $urandom_range(15);
    if (pick == 0) cp = lo;
    else if (pick == 1) cp = hi;
    else cp = 21'($urandom_range(hi, lo));
    // steer clear of surrogates here; they get their own noise case
    if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp ^ 21'h002000;
    send_encoded(cp, len, len);
  endtask

  task automatic test_ascii_and_no_buffer();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_rejected_leads();
    send_byte(8'h80, 1'b0);  // stray continuation
    send_byte(8'hC0, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hF5, 1'b0);  // above 10FFFF
    send_byte(8'hFF, 1'b0);  // too many leading ones
  endtask

  task automatic test_surrogates_and_range();
    // surrogate rejected, then finish as U+D7FF
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hBF, 1'b0);
    // above 10FFFF rejected, then finish as U+10FFFF
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  task automatic test_error_recovery();
    // ASCII and lead mid-sequence, overlong three-byte form, then U+0800
    send_byte(8'hE0, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    // overlong four-byte form, then U+10000
    send_byte(8'hF0, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  // Mostly well-formed text, with noise and broken sequences mixed in
  task automatic test_random_streams(input int unsigned n_bytes,
                                     input int unsigned send_idle,
                                     input int unsigned recv_stall);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = bytes_sent + n_bytes;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_random_scalar();
      end else if (pick < 88) begin
        send_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
      end else if (pick < 92) begin
        // truncated sequence: the next one starts mid-sequence
        len = $urandom_range(4, 2);
        send_encoded(21'($urandom_range(21'h10FFFF, 21'h10000)), len,
                     $urandom_range(len - 1, 1));
      end else if (pick < 95) begin
        // overlong form
        len = $urandom_range(4, 2);
        send_encoded(21'($urandom_range(21'h7FF >> (5 * (4 - len)))), len, len);
      end else if (pick < 98) begin
        send_encoded(21'($urandom_range(21'h00DFFF, 21'h00D800)), 3, 3);
      end else begin
        send_encoded(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4);
      end
    end
  endtask

  // Stop sending and let every expected result drain out
  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Test sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascii_and_no_buffer();
    test_rejected_leads();
    test_surrogates_and_range();
    test_error_recovery();

    test_random_streams(225, 0, 0);
    test_random_streams(225, 71, 0);
    test_random_streams(225, 0, 71);
    test_random_streams(225, 34, 34);
    drain_results();

    $display("Decoded %0d bytes: %0d code points completed, %0d bytes rejected,",
             bytes_sent, points_done, bytes_rejected);
    $display("under free-running, sender-idle, receiver-stall and mixed pacing.");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/udec_pkg.sv
hw/rtl/udec_fifo.sv
hw/rtl/udec_front.sv
hw/rtl/udec_back.sv
hw/rtl/utf8_byte_decoder_unit.sv
test/tb_top.sv
